>>> rtl/slcd_pkg.sv
`default_nettype none
package slcd_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'hFC;
  localparam logic [8:0] LEN_OFFSET = 9'd6;
  localparam logic [4:0] MAX_FRAME = 5'd22;
  localparam logic [4:0] LEN_POS = 5'd5;
  localparam logic [4:0] CMD_POS = 5'd1;
  localparam logic [4:0] INFO_POS = 5'd5;
  localparam logic [7:0] CMD_LINK_A = 8'h7A;
  localparam logic [7:0] CMD_LINK_B = 8'h7B;
  localparam logic [15:0] TIMEOUT_RESET = 16'd120;
  localparam logic [15:0] IDLE_MAX = 16'hFFFF;

  localparam logic [1:0] MODE_BYTE = 2'd0;
  localparam logic [1:0] MODE_TICK = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [2:0] ST_GOOD = 3'd0;
  localparam logic [2:0] ST_CHECKSUM = 3'd1;
  localparam logic [2:0] ST_LENGTH = 3'd2;
  localparam logic [2:0] ST_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_TIMEOUT = 3'd4;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [2:0]  frame_status;
    logic [7:0]  command_code;
    logic [4:0]  frame_length;
    logic [7:0]  sixth_byte;
    logic        link_up;
    logic [31:0] frames_seen;
    logic [31:0] errors_seen;
  } result_t;

endpackage
`default_nettype wire

>>> rtl/slcd_in_reg.sv
`default_nettype none
module slcd_in_reg (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire slcd_pkg::item_t in_item,
  output logic                 item_valid,
  output slcd_pkg::item_t      item,
  input  wire logic            down_ready
);

  logic            valid;
  slcd_pkg::item_t data;

  // stage empties or drains in the same cycle
  assign in_ready = !valid || down_ready;
  assign item_valid = valid;
  assign item = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= in_item;
    end
  end

endmodule
`default_nettype wire

>>> rtl/slcd_core.sv
`default_nettype none
module slcd_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_write_en,
  input  wire logic [15:0]     cfg_write_data,
  input  wire logic            item_valid,
  input  wire slcd_pkg::item_t item,
  input  wire logic            res_ready,
  output logic                 res_valid,
  output slcd_pkg::result_t    res
);

  logic [15:0] timeout_ticks;
  logic [4:0]  byte_index, byte_index_next;
  logic [4:0]  expected_length, expected_length_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  command_reg, command_reg_next;
  logic [7:0]  info_reg, info_reg_next;
  logic [15:0] idle_ticks, idle_ticks_next;
  logic        connected, connected_next;
  logic [31:0] frame_count, frame_count_next;
  logic [31:0] error_count, error_count_next;
  logic        go;
  logic        emit;
  logic [2:0]  status;
  logic [4:0]  length;

  assign go = item_valid && res_ready;

  always_comb begin
    logic [15:0] idle_inc;
    logic [4:0]  idx_new;
    logic [7:0]  sum_cur;
    logic [7:0]  cmd_new;
    logic [7:0]  info_new;
    logic [4:0]  exp_w;
    logic [8:0]  want_len;
    logic [7:0]  want_sum;
    logic        abort;

    byte_index_next = byte_index;
    expected_length_next = expected_length;
    running_sum_next = running_sum;
    command_reg_next = command_reg;
    info_reg_next = info_reg;
    idle_ticks_next = idle_ticks;
    connected_next = connected;
    frame_count_next = frame_count;
    error_count_next = error_count;
    emit = 1'b0;
    status = slcd_pkg::ST_GOOD;
    length = byte_index;
    abort = 1'b0;
    idle_inc = (idle_ticks == slcd_pkg::IDLE_MAX) ? idle_ticks : idle_ticks + 16'd1;
    idx_new = byte_index + 5'd1;
    // a sync byte with no frame open starts from a clean frame
    sum_cur = (byte_index == 5'd0) ? 8'd0 : running_sum;
    cmd_new = (byte_index == slcd_pkg::CMD_POS) ? item.rx_byte
            : (byte_index == 5'd0) ? 8'd0 : command_reg;
    info_new = (byte_index == slcd_pkg::INFO_POS) ? item.rx_byte
             : (byte_index == 5'd0) ? 8'd0 : info_reg;
    exp_w = (byte_index == slcd_pkg::CMD_POS || byte_index == 5'd0) ? 5'd0
          : expected_length;
    want_len = {1'b0, item.rx_byte} + slcd_pkg::LEN_OFFSET;
    want_sum = slcd_pkg::SYNC_BYTE - sum_cur;

    unique case (item.mode)
      slcd_pkg::MODE_CLEAR: begin
        connected_next = 1'b0;
        abort = 1'b1;
      end
      slcd_pkg::MODE_TICK: begin
        if (byte_index != 5'd0) begin
          if (idle_inc >= timeout_ticks) begin
            error_count_next = error_count + 32'd1;
            emit = 1'b1;
            status = slcd_pkg::ST_TIMEOUT;
            length = byte_index;
            abort = 1'b1;
          end else begin
            idle_ticks_next = idle_inc;
          end
        end
      end
      slcd_pkg::MODE_BYTE: begin
        if (byte_index != 5'd0 || item.rx_byte == slcd_pkg::SYNC_BYTE) begin
          byte_index_next = idx_new;
          running_sum_next = sum_cur + item.rx_byte;
          command_reg_next = cmd_new;
          info_reg_next = info_new;
          idle_ticks_next = 16'd0;
          length = idx_new;
          if (idx_new == slcd_pkg::LEN_POS && exp_w == 5'd0
              && want_len <= {4'd0, slcd_pkg::MAX_FRAME}) begin
            exp_w = want_len[4:0];
          end
          expected_length_next = exp_w;
          priority if (idx_new == slcd_pkg::LEN_POS && exp_w == 5'd0) begin
            // length byte out of range
            error_count_next = error_count + 32'd1;
            emit = 1'b1;
            status = slcd_pkg::ST_LENGTH;
            abort = 1'b1;
          end else if (exp_w != 5'd0 && idx_new >= exp_w) begin
            frame_count_next = frame_count + 32'd1;
            emit = 1'b1;
            abort = 1'b1;
            if (item.rx_byte != want_sum) begin
              error_count_next = error_count + 32'd1;
              status = slcd_pkg::ST_CHECKSUM;
            end else begin
              status = slcd_pkg::ST_GOOD;
              if (cmd_new == slcd_pkg::CMD_LINK_A || cmd_new == slcd_pkg::CMD_LINK_B) begin
                connected_next = 1'b1;
              end
            end
          end else if (idx_new >= slcd_pkg::MAX_FRAME) begin
            // guard only, a legal length always completes first
            error_count_next = error_count + 32'd1;
            emit = 1'b1;
            status = slcd_pkg::ST_OVERFLOW;
            abort = 1'b1;
          end else begin
            emit = 1'b0;
          end
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase

    res.frame_status = status;
    res.command_code = command_reg_next;
    res.frame_length = length;
    res.sixth_byte = info_reg_next;
    res.link_up = connected_next;
    res.frames_seen = frame_count_next;
    res.errors_seen = error_count_next;

    if (abort) begin
      byte_index_next = 5'd0;
      expected_length_next = 5'd0;
      running_sum_next = 8'd0;
      command_reg_next = 8'd0;
      info_reg_next = 8'd0;
      idle_ticks_next = 16'd0;
    end
  end

  assign res_valid = go && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= slcd_pkg::TIMEOUT_RESET;
    end else if (cfg_write_en) begin
      timeout_ticks <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= 5'd0;
      expected_length <= 5'd0;
      running_sum <= 8'd0;
      command_reg <= 8'd0;
      info_reg <= 8'd0;
      idle_ticks <= 16'd0;
      connected <= 1'b0;
      frame_count <= 32'd0;
      error_count <= 32'd0;
    end else if (go) begin
      byte_index <= byte_index_next;
      expected_length <= expected_length_next;
      running_sum <= running_sum_next;
      command_reg <= command_reg_next;
      info_reg <= info_reg_next;
      idle_ticks <= idle_ticks_next;
      connected <= connected_next;
      frame_count <= frame_count_next;
      error_count <= error_count_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/slcd_out_reg.sv
`default_nettype none
module slcd_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              res_valid,
  input  wire slcd_pkg::result_t res,
  output logic                   res_ready,
  output logic                   out_valid,
  output slcd_pkg::result_t      out_res,
  input  wire logic              out_ready
);

  logic              valid;
  slcd_pkg::result_t data;

  assign res_ready = !valid || out_ready;
  assign out_valid = valid;
  assign out_res = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (res_ready) begin
      valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      data <= res;
    end
  end

endmodule
`default_nettype wire

>>> rtl/sync_length_checksum_deframer_top.sv
// Deframer for a byte stream with a sync byte, a length field and a checksum.
// Input channel (in_valid/in_ready) carries one event per transaction: mode 0
// is a received byte in rx_byte, mode 1 a one-millisecond tick, mode 2 drops
// the link flag and any partial frame. Output channel (out_valid/out_ready)
// gives one transaction per frame event: completed frame, checksum, length,
// overflow or timeout error, with the running frame and error counters.
// Events that end nothing produce no output transaction.
// One transaction is accepted every cycle while in_ready is high; an accepted
// event is captured in the input register, processed by the core logic, and
// its result is captured in the result register, from which it is presented.
// The state update is a single pass of logic per event.
// When the receiver stalls, the result register holds its transaction and the
// input register fills, after which in_ready drops until out_ready returns.
// cfg_write_en/cfg_write_data load the idle timeout in ticks; write it only
// while no transaction is in flight.
// Synchronous reset clears the frame state, the link flag, both counters and
// sets the timeout to 120 ticks.
`default_nettype none
module sync_length_checksum_deframer_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write_en,
  input  wire logic [15:0] cfg_write_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  mode,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       frame_status,
  output logic [7:0]       command_code,
  output logic [4:0]       frame_length,
  output logic [7:0]       sixth_byte,
  output logic             link_up,
  output logic [31:0]      frames_seen,
  output logic [31:0]      errors_seen
);

  slcd_pkg::item_t   in_item;
  slcd_pkg::item_t   item;
  logic              item_valid;
  logic              res_valid;
  logic              res_ready;
  slcd_pkg::result_t res;
  slcd_pkg::result_t out_res;

  assign in_item.mode = mode;
  assign in_item.rx_byte = rx_byte;

  slcd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .down_ready (res_ready)
  );

  slcd_core u_core (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .item_valid     (item_valid),
    .item           (item),
    .res_ready      (res_ready),
    .res_valid      (res_valid),
    .res            (res)
  );

  slcd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .out_valid (out_valid),
    .out_res   (out_res),
    .out_ready (out_ready)
  );

  assign frame_status = out_res.frame_status;
  assign command_code = out_res.command_code;
  assign frame_length = out_res.frame_length;
  assign sixth_byte = out_res.sixth_byte;
  assign link_up = out_res.link_up;
  assign frames_seen = out_res.frames_seen;
  assign errors_seen = out_res.errors_seen;

endmodule
`default_nettype wire

>>> tb/deframer_checker.sv
module deframer_checker
  import slcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [15:0] cfg_write_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  frame_status,
  input  logic [7:0]  command_code,
  input  logic [4:0]  frame_length,
  input  logic [7:0]  sixth_byte,
  input  logic        link_up,
  input  logic [31:0] frames_seen,
  input  logic [31:0] errors_seen,
  output int          mismatches,
  output int          pending
);

  // shadow copy of the deframer state
  logic [15:0] timeout_limit;
  logic [4:0]  pos_count;
  logic [4:0]  want_length;
  logic [7:0]  byte_sum;
  logic [7:0]  cmd_seen;
  logic [7:0]  info_seen;
  logic [15:0] idle_count;
  logic        link_flag;
  logic [31:0] frame_total;
  logic [31:0] error_total;

  result_t predicted_reports[$];
  int      fault_total = 0;

  function automatic void drop_frame();
    pos_count   = '0;
    want_length = '0;
    byte_sum    = '0;
    cmd_seen    = '0;
    info_seen   = '0;
    idle_count  = '0;
  endfunction

  function automatic result_t frame_report(input logic [2:0] status, input logic [4:0] len);
    result_t r;
    r.frame_status = status;
    r.command_code = cmd_seen;
    r.frame_length = len;
    r.sixth_byte   = info_seen;
    r.link_up      = link_flag;
    r.frames_seen  = frame_total;
    r.errors_seen  = error_total;
    return r;
  endfunction

  // advances the shadow state by one event, returns 1 when a report is due
  function automatic bit deframe_event(input logic [1:0] md, input logic [7:0] b,
                                       output result_t r);
    logic [4:0] pos;
    logic [7:0] sum_before;
    logic [8:0] len_calc;
    r = '0;
    if (md == MODE_CLEAR) begin
      link_flag = 1'b0;
      drop_frame();
      return 1'b0;
    end
    if (md == MODE_TICK) begin
      if (pos_count == 0) return 1'b0;
      if (idle_count < IDLE_MAX) idle_count++;
      if (idle_count >= timeout_limit) begin
        error_total++;
        r = frame_report(ST_TIMEOUT, pos_count);
        drop_frame();
        return 1'b1;
      end
      return 1'b0;
    end
    if (md != MODE_BYTE) return 1'b0;

    // nothing open: only the sync byte starts a frame
    if (pos_count == 0) begin
      if (b != SYNC_BYTE) return 1'b0;
      drop_frame();
    end

    pos        = pos_count;
    sum_before = byte_sum;
    pos_count  = pos + 5'd1;
    byte_sum   = byte_sum + b;
    idle_count = '0;
    if (pos == CMD_POS) begin
      cmd_seen    = b;
      want_length = '0;
    end
    if (pos == INFO_POS) info_seen = b;

    if (pos_count == LEN_POS && want_length == 0) begin
      len_calc = {1'b0, b} + LEN_OFFSET;
      if (len_calc > {4'b0, MAX_FRAME}) begin
        error_total++;
        r = frame_report(ST_LENGTH, pos_count);
        drop_frame();
        return 1'b1;
      end
      want_length = len_calc[4:0];
    end

    if (want_length > 0 && pos_count >= want_length) begin
      frame_total++;
      if (b != SYNC_BYTE - sum_before) begin
        error_total++;
        r = frame_report(ST_CHECKSUM, pos_count);
      end else begin
        if (cmd_seen == CMD_LINK_A || cmd_seen == CMD_LINK_B) link_flag = 1'b1;
        r = frame_report(ST_GOOD, pos_count);
      end
      drop_frame();
      return 1'b1;
    end

    // guard only, a legal maximum never gets here
    if (pos_count >= MAX_FRAME) begin
      error_total++;
      r = frame_report(ST_OVERFLOW, pos_count);
      drop_frame();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin : watch
    result_t predicted;
    result_t observed;
    bit      due;
    if (rst) begin
      timeout_limit = TIMEOUT_RESET;
      drop_frame();
      link_flag   = 1'b0;
      frame_total = '0;
      error_total = '0;
      predicted_reports.delete();
    end else begin
      if (cfg_write_en) timeout_limit = cfg_write_data;
      if (in_valid && in_ready) begin
        due = deframe_event(mode, rx_byte, predicted);
        if (due) predicted_reports.push_back(predicted);
      end
      if (out_valid && out_ready) begin
        observed.frame_status = frame_status;
        observed.command_code = command_code;
        observed.frame_length = frame_length;
        observed.sixth_byte   = sixth_byte;
        observed.link_up      = link_up;
        observed.frames_seen  = frames_seen;
        observed.errors_seen  = errors_seen;
        if (predicted_reports.size() == 0) begin
          fault_total++;
          if (fault_total <= 10)
            $display("unexpected result transaction: status %0d cmd %0h len %0d",
                     frame_status, command_code, frame_length);
        end else begin
          predicted = predicted_reports.pop_front();
          if (observed.frame_status !== predicted.frame_status ||
              observed.command_code !== predicted.command_code ||
              observed.frame_length !== predicted.frame_length ||
              observed.sixth_byte   !== predicted.sixth_byte   ||
              observed.link_up      !== predicted.link_up      ||
              observed.frames_seen  !== predicted.frames_seen  ||
              observed.errors_seen  !== predicted.errors_seen) begin
            fault_total++;
            if (fault_total <= 10) begin
              $display("expected status %0d cmd %0h len %0d info %0h link %0d frm %0d err %0d",
                       predicted.frame_status, predicted.command_code, predicted.frame_length,
                       predicted.sixth_byte, predicted.link_up, predicted.frames_seen,
                       predicted.errors_seen);
              $display("actual   status %0d cmd %0h len %0d info %0h link %0d frm %0d err %0d",
                       observed.frame_status, observed.command_code, observed.frame_length,
                       observed.sixth_byte, observed.link_up, observed.frames_seen,
                       observed.errors_seen);
            end
          end
        end
      end
    end
    pending    <= predicted_reports.size();
    mismatches <= fault_total;
  end

endmodule

>>> tb/tb_sync_length_checksum_deframer_top.sv
module tb_sync_length_checksum_deframer_top;
  import slcd_pkg::*;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int STALL_LIMIT = 1000;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_write_en = 1'b0;
  logic [15:0] cfg_write_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  mode = MODE_BYTE;
  logic [7:0]  rx_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  frame_status;
  logic [7:0]  command_code;
  logic [4:0]  frame_length;
  logic [7:0]  sixth_byte;
  logic        link_up;
  logic [31:0] frames_seen;
  logic [31:0] errors_seen;
  int          mismatches;
  int          pending;

  bit          idling_on = 1'b1;
  int          items_sent = 0;
  logic [15:0] timeout_now = TIMEOUT_RESET;
  int          quiet_cycles = 0;

  sync_length_checksum_deframer_top dut (
    .clk(clk), .rst(rst),
    .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
    .in_valid(in_valid), .in_ready(in_ready), .mode(mode), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .frame_status(frame_status), .command_code(command_code),
    .frame_length(frame_length), .sixth_byte(sixth_byte), .link_up(link_up),
    .frames_seen(frames_seen), .errors_seen(errors_seen)
  );

  deframer_checker frame_check (
    .clk(clk), .rst(rst),
    .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
    .in_valid(in_valid), .in_ready(in_ready), .mode(mode), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .frame_status(frame_status), .command_code(command_code),
    .frame_length(frame_length), .sixth_byte(sixth_byte), .link_up(link_up),
    .frames_seen(frames_seen), .errors_seen(errors_seen),
    .mismatches(mismatches), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) out_ready <= idling_on ? ($urandom_range(99) >= 24) : 1'b1;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_event(input logic [1:0] md, input logic [7:0] b);
    if (idling_on)
      while ($urandom_range(99) < 24) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_valid <= 1'b1;
    mode     <= md;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_ticks(input int n);
    for (int k = 0; k < n; k++) send_event(MODE_TICK, 8'($urandom));
  endtask

  // cut of 0, or of at least the frame length, sends the whole frame, otherwise only the first cut bytes
  task automatic send_frame(input logic [7:0] cmd, input logic [7:0] len_code,
                            input logic [7:0] info, input bit bad_sum, input int cut);
    logic [7:0] fb[32];
    logic [7:0] acc;
    int total;
    int n;
    total = int'(len_code) + 6;
    fb[0] = SYNC_BYTE;
    fb[1] = cmd;
    fb[2] = 8'($urandom);
    fb[3] = 8'($urandom);
    fb[4] = len_code;
    if (total > MAX_FRAME) begin
      total = 5;
    end else begin
      for (int k = 5; k < total; k++) fb[k] = 8'($urandom);
      if (total > 6) fb[5] = info;
      acc = '0;
      for (int k = 0; k < total - 1; k++) acc = acc + fb[k];
      fb[total-1] = SYNC_BYTE - acc;
      if (bad_sum) fb[total-1] = fb[total-1] ^ 8'($urandom_range(1, 255));
    end
    n = (cut > 0 && cut < total) ? cut : total;
    for (int k = 0; k < n; k++) send_event(MODE_BYTE, fb[k]);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] v);
    settle();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    timeout_now = v;
  endtask

  task automatic run_mix(input int quota);
    int stop;
    int r;
    int ticks;
    logic [7:0] cmd;
    logic [7:0] len_code;
    stop = items_sent + quota;
    while (items_sent < stop) begin
      r = $urandom_range(99);
      if ($urandom_range(3) == 0) cmd = $urandom_range(1) ? CMD_LINK_B : CMD_LINK_A;
      else cmd = 8'($urandom);
      // mostly short frames, now and then up to the maximum length
      len_code = ($urandom_range(99) < 80) ? 8'($urandom_range(4)) : 8'($urandom_range(16));
      if (r < 55) begin
        send_frame(cmd, len_code, 8'($urandom), $urandom_range(99) < 15, 0);
      end else if (r < 65) begin
        send_frame(cmd, 8'($urandom_range(17, 255)), 8'h00, 1'b0, 0);
      end else if (r < 77) begin
        send_frame(cmd, len_code, 8'($urandom), 1'b0,
                   $urandom_range(1, int'(len_code) + 5));
        ticks = $urandom_range(1) ? int'(timeout_now) : $urandom_range(3);
        if (ticks > 200) ticks = 200;
        send_ticks(ticks);
      end else if (r < 84) begin
        send_ticks($urandom_range(1, 6));
      end else if (r < 89) begin
        send_event(MODE_CLEAR, 8'($urandom));
      end else if (r < 93) begin
        send_event(MODE_SPARE, 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 3)) send_event(MODE_BYTE, 8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // stray bytes, idle tick and unused mode give nothing
    send_event(MODE_BYTE, 8'h00);
    send_event(MODE_BYTE, 8'hFF);
    send_event(MODE_TICK, 8'h00);
    send_event(MODE_SPARE, 8'hFC);
    // shortest frame that brings the link up, then clear it
    send_frame(CMD_LINK_A, 8'd0, 8'h00, 1'b0, 0);
    send_event(MODE_CLEAR, 8'h00);
    // length one past the maximum
    send_frame(8'hFF, 8'd17, 8'h00, 1'b0, 0);
    send_frame(CMD_LINK_B, 8'd1, 8'h62, 1'b1, 0);
    // zero timeout drops the frame on the first tick
    write_timeout(16'd0);
    send_event(MODE_BYTE, SYNC_BYTE);
    send_event(MODE_TICK, 8'hFF);
    write_timeout(TIMEOUT_RESET);

    run_mix(125);
    write_timeout(16'd3);
    idling_on <= 1'b0;
    run_mix(125);
    idling_on <= 1'b1;
    write_timeout(16'd1);
    run_mix(125);
    write_timeout(16'd10);
    run_mix(125);
    write_timeout(16'hFFFF);
    run_mix(125);

    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
